// ===== rtl/rgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgs_pkg: shared types and constants of the ramped gain smoother
// Holds the action codes and the command and status words that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rgs_pkg;

  // Extra fraction bits carried by the running gain below the Q4.F gain.
  localparam int unsigned EXTRA_BITS = 20;

  // Width of the ramp length configuration register.
  localparam int unsigned RAMP_REG_BITS = 16;

  // Width of the new target gain field.
  localparam int unsigned NEW_GAIN_BITS = 24;

  // Action codes of an input word.
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_SET    = 2'd1,
    ACT_SNAP   = 2'd2
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;
    logic set_target;
    logic snap;
    logic load_out;
    logic div_step;
    logic div_finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;
  } status_t;

endpackage

// ===== rtl/rgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgs_ctrl: controller of the ramped gain smoother
// Sequences sample scaling and the bit-serial increment division, and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module rgs_ctrl import rgs_pkg::*; #(
  parameter int unsigned DIV_STEPS = 44
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  localparam int unsigned CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;

  assign in_stall_o  = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_i)
            ACT_SAMPLE: begin
              cmd_o.take_sample = 1'b1;
              state_d           = ST_MUL;
            end
            ACT_SET: begin
              cmd_o.set_target = 1'b1;
              if (!status_i.trivial) begin
                cnt_d   = '0;
                state_d = ST_DIV;
              end
            end
            ACT_SNAP: begin
              cmd_o.snap = 1'b1;
            end
            default: begin
              // The spare action code is dropped without effect.
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.load_out = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/rgs_datapath.sv =====
// ----------------------------------------------------------------------------
// rgs_datapath: datapath of the ramped gain smoother
// Holds the gain state, the ramp length register, the sample multiplier with
// rounding and saturation, and a restoring divider that yields one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module rgs_datapath import rgs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned GAIN_FRAC_BITS  = 20,
  parameter int unsigned RAMP_COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [RAMP_REG_BITS-1:0]            cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  input  logic                                frame_end_i,
  input  logic [NEW_GAIN_BITS-1:0]            new_gain_i,
  input  cmd_t                                cmd_i,
  output status_t                             status_o,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic [GAIN_FRAC_BITS+3:0]           gain_now_o,
  output logic                                ramping_o
);

  localparam int unsigned GB    = GAIN_FRAC_BITS + 4;
  localparam int unsigned GC_W  = GB + EXTRA_BITS;
  localparam int unsigned ST_W  = GC_W + 1;
  localparam int unsigned RC    = RAMP_COUNT_BITS;
  localparam int unsigned CMP_W = (GB > NEW_GAIN_BITS) ? GB : NEW_GAIN_BITS;
  localparam int unsigned N_W   = (RC > RAMP_REG_BITS) ? RC : RAMP_REG_BITS;
  localparam int unsigned PW    = SAMPLE_BITS + GB;
  localparam int unsigned Q_W   = PW + 1 - GAIN_FRAC_BITS;

  // Control state: gain, target, increment and remaining steps.
  logic [RAMP_REG_BITS-1:0] ramp_q;
  logic [GC_W-1:0]          gain_q;
  logic [GB-1:0]            target_q;
  logic signed [ST_W-1:0]   step_q;
  logic [RC-1:0]            left_q;

  // Divider registers.
  logic [GC_W-1:0]          dquo_q;
  logic [RC:0]              drem_q;
  logic [RC-1:0]            dn_q;
  logic                     dneg_q;

  // Multiplier stage and output payload.
  logic [PW-1:0]            prod_q;
  logic                     pneg_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic [GB-1:0]            out_gain_q;
  logic                     out_ramp_q;

  // Set-target arithmetic.
  logic [CMP_W-1:0]         ng_w;
  logic [GB-1:0]            target_new;
  logic [N_W-1:0]           n_w;
  logic [RC-1:0]            n_new;
  logic [GC_W-1:0]          full_new;
  logic signed [ST_W-1:0]   diff;
  logic signed [ST_W-1:0]   diff_mag;

  always_comb begin
    ng_w       = CMP_W'(new_gain_i);
    target_new = (ng_w > CMP_W'({GB{1'b1}})) ? {GB{1'b1}} : ng_w[GB-1:0];
    n_w        = N_W'(ramp_q);
    n_new      = n_w[RC-1:0];
    full_new   = {target_new, {EXTRA_BITS{1'b0}}};
    diff       = $signed({1'b0, full_new}) - $signed({1'b0, gain_q});
    diff_mag   = diff[ST_W-1] ? -diff : diff;
  end

  assign status_o.trivial = (n_new == '0) || (gain_q == full_new);

  // Divider step.
  logic [RC:0]  rem_sh;
  logic         ge;
  logic [ST_W-1:0] q_ext;

  always_comb begin
    rem_sh = {drem_q[RC-1:0], dquo_q[GC_W-1]};
    ge     = rem_sh >= {1'b0, dn_q};
    q_ext  = {1'b0, dquo_q};
  end

  // Sample magnitude and ramp advance.
  logic                   s_neg;
  logic [SAMPLE_BITS-1:0] s_mag;
  logic [RC-1:0]          left_dec;
  logic                   adv;

  always_comb begin
    s_neg    = sample_in_i[SAMPLE_BITS-1];
    s_mag    = s_neg ? SAMPLE_BITS'(-sample_in_i) : SAMPLE_BITS'(sample_in_i);
    adv      = frame_end_i && (left_q != '0);
    left_dec = left_q - 1'b1;
  end

  // Rounding and saturation of the registered product.
  logic [PW:0]            rsum;
  logic [Q_W-1:0]         q_val;
  logic [Q_W-1:0]         q_lim;
  logic [SAMPLE_BITS-1:0] q_sat;

  always_comb begin
    rsum  = {1'b0, prod_q} + (PW + 1)'({1'b1, {(GAIN_FRAC_BITS - 1){1'b0}}});
    q_val = rsum[PW:GAIN_FRAC_BITS];
    q_lim = pneg_q ? Q_W'({1'b1, {(SAMPLE_BITS - 1){1'b0}}})
                   : Q_W'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    q_sat = (q_val > q_lim) ? q_lim[SAMPLE_BITS-1:0] : q_val[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q   <= '0;
      gain_q   <= '0;
      target_q <= '0;
      step_q   <= '0;
      left_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        ramp_q <= cfg_wdata_i;
      end
      if (cmd_i.take_sample && adv) begin
        left_q <= left_dec;
        if (left_dec == '0) begin
          gain_q <= {target_q, {EXTRA_BITS{1'b0}}};
          step_q <= '0;
        end else begin
          gain_q <= gain_q + step_q[GC_W-1:0];
        end
      end
      if (cmd_i.set_target) begin
        target_q <= target_new;
        if (status_o.trivial) begin
          gain_q <= full_new;
          step_q <= '0;
          left_q <= '0;
        end
      end
      if (cmd_i.snap) begin
        gain_q <= {target_q, {EXTRA_BITS{1'b0}}};
        step_q <= '0;
        left_q <= '0;
      end
      if (cmd_i.div_finish) begin
        step_q <= dneg_q ? -$signed(q_ext) : $signed(q_ext);
        left_q <= dn_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_target) begin
      dquo_q <= diff_mag[GC_W-1:0];
      drem_q <= '0;
      dn_q   <= n_new;
      dneg_q <= diff[ST_W-1];
    end else if (cmd_i.div_step) begin
      drem_q <= ge ? (rem_sh - {1'b0, dn_q}) : rem_sh;
      dquo_q <= {dquo_q[GC_W-2:0], ge};
    end
    if (cmd_i.take_sample) begin
      prod_q     <= PW'(s_mag) * PW'(gain_q[GC_W-1:EXTRA_BITS]);
      pneg_q     <= s_neg;
      out_gain_q <= gain_q[GC_W-1:EXTRA_BITS];
      out_ramp_q <= adv ? (left_dec != '0) : (left_q != '0);
    end
    if (cmd_i.load_out) begin
      out_sample_q <= pneg_q ? -$signed(q_sat) : $signed(q_sat);
    end
  end

  assign sample_out_o = out_sample_q;
  assign gain_now_o   = out_gain_q;
  assign ramping_o    = out_ramp_q;

endmodule

// ===== rtl/ramped_gain_smoother.sv =====
// ----------------------------------------------------------------------------
// ramped_gain_smoother: audio gain with a linear ramp toward a target
// Scales signed samples by a running gain that moves one step per frame
// toward a target, landing on it exactly at the last step.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+---------------------------------
//   input    | in_valid_i / in_stall_o     | action, sample_in, frame_end,
//            |                             | new_gain
//   output   | out_valid_o / out_stall_i   | sample_out, gain_now, ramping
//   config   | cfg_we_i                    | cfg_wdata_i (ramp_samples)
//
// For a sample word the multiplier output is registered, then the product is
// rounded and saturated into the output register. A snap word takes effect
// as soon as it is taken. A set-target word that starts a ramp stalls the
// input while the restoring divider forms one quotient bit of the increment
// per cycle, then loads the increment and the step count.
// Reset is asynchronous and active low; it clears gain, target, increment,
// step count and ramp length. A word is taken while the previous result still
// waits only if that result leaves in the same cycle.
// ----------------------------------------------------------------------------
module ramped_gain_smoother import rgs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned GAIN_FRAC_BITS  = 20,
  parameter int unsigned RAMP_COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: ramp length in sample frames.
  input  logic                          cfg_we_i,
  input  logic [RAMP_REG_BITS-1:0]      cfg_wdata_i,
  // Input words.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          frame_end_i,
  input  logic [NEW_GAIN_BITS-1:0]      new_gain_i,
  // Output words.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic [GAIN_FRAC_BITS+3:0]     gain_now_o,
  output logic                          ramping_o
);

  // The divider runs once per bit of the running gain.
  localparam int unsigned DIV_STEPS = GAIN_FRAC_BITS + 4 + EXTRA_BITS;

  cmd_t    cmd;
  status_t status;

  // The controller decides when words are taken and which datapath
  // operation runs in each cycle.
  rgs_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds all gain state and the output payload registers.
  rgs_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
    .RAMP_COUNT_BITS (RAMP_COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (sample_in_i),
    .frame_end_i  (frame_end_i),
    .new_gain_i   (new_gain_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_out_o (sample_out_o),
    .gain_now_o   (gain_now_o),
    .ramping_o    (ramping_o)
  );

endmodule
